// ----- src/psls_pkg.sv -----
// Shared types and constants for the per-second silence and loudness statistics block.
package psls_pkg;

  localparam int SECONDS_BITS = 24;
  localparam int FRAME_BITS   = 20;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W + 1;
  localparam int SIL_W      = 15;
  localparam int LOUD_W     = 15;
  localparam int LCNT_W     = 20;
  localparam int FRAC_W     = 17;
  localparam int SPS_W      = 20;
  localparam int PCT_W      = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 3 * SECONDS_BITS + 2 * PCT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int PROD_W = FRAC_W + FRAME_BITS;
  localparam int QSH_W  = FRAME_BITS + 16;

  // Percent divider: quotient of n*1000/wave never exceeds 1000.
  localparam int QUO_W  = 11;
  localparam int NUM_W  = SECONDS_BITS + 10;
  localparam int STEP_W = $clog2(QUO_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [FRAME_BITS-1:0]   FRAME_MAX = {FRAME_BITS{1'b1}};
  localparam logic [SECONDS_BITS-1:0] SEC_MAX   = {SECONDS_BITS{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SILENCE_LIMIT  = 3'd0,
    REG_LOUD_THRESHOLD = 3'd1,
    REG_LOUD_CNT_LIMIT = 3'd2,
    REG_SILENT_FRAC    = 3'd3,
    REG_SAMPLES_PER_S  = 3'd4,
    REG_EIGHT_BIT      = 3'd5
  } reg_idx_t;

  localparam logic [SIL_W-1:0]  RST_SILENCE_LIMIT  = 15'd100;
  localparam logic [LOUD_W-1:0] RST_LOUD_THRESHOLD = 15'd26000;
  localparam logic [LCNT_W-1:0] RST_LOUD_CNT_LIMIT = 20'd8;
  localparam logic [FRAC_W-1:0] RST_SILENT_FRAC    = 17'd39322;
  localparam logic [SPS_W-1:0]  RST_SAMPLES_PER_S  = 20'd16000;

  typedef struct packed {
    logic [SIL_W-1:0]  silence_limit;
    logic [LOUD_W-1:0] loud_threshold;
    logic [LCNT_W-1:0] loud_count_limit;
    logic [FRAC_W-1:0] silent_fraction_q16;
    logic [SPS_W-1:0]  samples_per_second;
    logic              eight_bit_mode;
  } cfg_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic finish;
    logic quiet;
    logic loud;
  } item_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

// ----- src/per_second_silence_loudness_stats_core.sv -----
// Per-second silence and loudness statistics: top level with config registers.
//
// Input stream: each word is one 16-bit PCM sample (in_tuser = 0) or a finish
// command (in_tuser = 1). Samples are grouped into frames of samples_per_second
// words; every complete frame is judged silent and/or loud. A finish word emits
// one result word (wave, silent and loud seconds, silent and loud percent) and
// clears all counts; a trailing partial frame is discarded.
// A front stage classifies each sample and pushes it into a 4-word queue; the
// back end updates the counters. Samples stream at one per cycle while the back
// end is in its run state; it takes no queue words while it handles a finish.
// A finish word makes the back end load the two percent dividers, run 11
// restoring-division steps (one quotient bit per cycle), then load the result
// register. While the receiver stalls, the result register holds its word;
// the back end waits with the next finish, and samples keep flowing until the
// queue fills. Reset (rst_n low, synchronous) restores register defaults and
// clears all counts, the queue and the result valid flag. Configuration is
// written by cfg_we/cfg_addr/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. Unknown indexes are
// ignored.
module per_second_silence_loudness_stats_core import psls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                   in_tuser,   // [0] action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [23:0] wave_seconds, [47:24] silent_seconds, [71:48] loud_seconds,
  // [78:72] silent_percent, [85:79] loud_percent
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t  cfg_r;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.silence_limit       <= RST_SILENCE_LIMIT;
      cfg_r.loud_threshold      <= RST_LOUD_THRESHOLD;
      cfg_r.loud_count_limit    <= RST_LOUD_CNT_LIMIT;
      cfg_r.silent_fraction_q16 <= RST_SILENT_FRAC;
      cfg_r.samples_per_second  <= RST_SAMPLES_PER_S;
      cfg_r.eight_bit_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SILENCE_LIMIT:  cfg_r.silence_limit       <= cfg_wdata[SIL_W-1:0];
        REG_LOUD_THRESHOLD: cfg_r.loud_threshold      <= cfg_wdata[LOUD_W-1:0];
        REG_LOUD_CNT_LIMIT: cfg_r.loud_count_limit    <= cfg_wdata[LCNT_W-1:0];
        REG_SILENT_FRAC:    cfg_r.silent_fraction_q16 <= cfg_wdata[FRAC_W-1:0];
        REG_SAMPLES_PER_S:  cfg_r.samples_per_second  <= cfg_wdata[SPS_W-1:0];
        REG_EIGHT_BIT:      cfg_r.eight_bit_mode      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  psls_front u_front (
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  psls_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  psls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- src/psls_front.sv -----
// Front end: takes input words and classifies each sample as quiet and/or loud.
module psls_front import psls_pkg::*; (
  input  cfg_t                  cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  push_valid,
  input  logic                  push_ready,
  output item_t                 push_item
);

  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] raw_ext;

  assign raw_ext = {in_tdata[SAMPLE_W-1], in_tdata[SAMPLE_W-1:0]};

  always_comb begin
    if (cfg.eight_bit_mode) begin
      mag = '0;
    end else if (in_tdata[SAMPLE_W-1]) begin
      mag = MAG_W'(-raw_ext);
    end else begin
      mag = raw_ext;
    end
  end

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_item.finish = in_tuser;
    push_item.quiet  = (mag <= MAG_W'(cfg.silence_limit));
    push_item.loud   = (mag >= MAG_W'(cfg.loud_threshold));
  end

endmodule

// ----- src/psls_queue.sv -----
// Short register queue between the front and the back.
module psls_queue import psls_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/psls_back.sv -----
// Back end: frame counters, second classification, percent divider and result register.
module psls_back import psls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  item_t                  pop_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  back_state_t state_r, state_nxt;

  logic [FRAME_BITS-1:0]   sif_r, sif_nxt;
  logic [FRAME_BITS-1:0]   quiet_r, quiet_nxt;
  logic [FRAME_BITS-1:0]   loud_r, loud_nxt;
  logic [SECONDS_BITS-1:0] full_r, full_nxt;
  logic [SECONDS_BITS-1:0] silent_r, silent_nxt;
  logic [SECONDS_BITS-1:0] loudsec_r, loudsec_nxt;

  logic [FRAME_BITS-1:0] frame_len;
  logic [PROD_W-1:0]     prod_r;

  logic [NUM_W-1:0]    rem_s_r, rem_s_nxt;
  logic [NUM_W-1:0]    rem_l_r, rem_l_nxt;
  logic [NUM_W-1:0]    dsh_r, dsh_nxt;
  logic [QUO_W-1:0]    q_s_r, q_s_nxt;
  logic [QUO_W-1:0]    q_l_r, q_l_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SECONDS_BITS-1:0] wave;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [FRAME_BITS-1:0] sif_inc, quiet_inc, loud_inc;
  logic                  frame_done, is_silent, is_loud;
  logic                  take;
  logic                  out_free;
  logic                  ge_s, ge_l;
  logic [PCT_W-1:0]      pct_s, pct_l;

  // (q + 5) / 10 for q <= 1000, by reciprocal multiply
  function automatic logic [PCT_W-1:0] round_pct(input logic [QUO_W-1:0] q);
    logic [QUO_W:0]    qa;
    logic [QUO_W+8:0]  m;
    qa = (QUO_W+1)'(q) + (QUO_W+1)'(5);
    m  = (QUO_W+9)'(qa) * (QUO_W+9)'(205);
    return m[QUO_W+6:QUO_W];
  endfunction

  function automatic logic [SECONDS_BITS-1:0] sat_inc(input logic [SECONDS_BITS-1:0] v);
    return (v == SEC_MAX) ? v : v + 1'b1;
  endfunction

  assign frame_len = (cfg.samples_per_second == '0) ? FRAME_BITS'(1)
                                                    : FRAME_BITS'(cfg.samples_per_second);

  // Threshold for a silent second; registered from the configured fraction and frame length
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(cfg.silent_fraction_q16) * PROD_W'(frame_len);
  end

  assign wave      = sat_inc(full_r);
  assign out_free  = !out_valid_r || out_tready;
  assign pop_ready = (state_r == ST_RUN);
  assign take      = pop_valid && pop_ready;

  assign sif_inc   = (sif_r == FRAME_MAX) ? sif_r : sif_r + 1'b1;
  assign quiet_inc = (pop_item.quiet && quiet_r != FRAME_MAX) ? quiet_r + 1'b1 : quiet_r;
  assign loud_inc  = (pop_item.loud && loud_r != FRAME_MAX) ? loud_r + 1'b1 : loud_r;
  assign frame_done = (sif_inc >= frame_len);
  assign is_silent  = (PROD_W'({quiet_inc, 16'd0}) > prod_r);
  assign is_loud    = (LCNT_W'(loud_inc) > cfg.loud_count_limit);

  assign ge_s  = (rem_s_r >= dsh_r);
  assign ge_l  = (rem_l_r >= dsh_r);
  assign pct_s = round_pct(q_s_r);
  assign pct_l = round_pct(q_l_r);

  always_comb begin
    state_nxt     = state_r;
    sif_nxt       = sif_r;
    quiet_nxt     = quiet_r;
    loud_nxt      = loud_r;
    full_nxt      = full_r;
    silent_nxt    = silent_r;
    loudsec_nxt   = loudsec_r;
    rem_s_nxt     = rem_s_r;
    rem_l_nxt     = rem_l_r;
    dsh_nxt       = dsh_r;
    q_s_nxt       = q_s_r;
    q_l_nxt       = q_l_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_RUN: begin
        if (take && pop_item.finish) begin
          // n*1000 = n*1024 - n*16 - n*8; divisor starts at wave << (QUO_W-1)
          rem_s_nxt = (NUM_W'(silent_r) << 10) - (NUM_W'(silent_r) << 4)
                    - (NUM_W'(silent_r) << 3);
          rem_l_nxt = (NUM_W'(loudsec_r) << 10) - (NUM_W'(loudsec_r) << 4)
                    - (NUM_W'(loudsec_r) << 3);
          dsh_nxt   = NUM_W'(wave) << (QUO_W - 1);
          q_s_nxt   = '0;
          q_l_nxt   = '0;
          step_nxt  = STEP_W'(QUO_W - 1);
          state_nxt = ST_DIV;
        end else if (take) begin
          if (frame_done) begin
            full_nxt = sat_inc(full_r);
            if (is_silent) silent_nxt = sat_inc(silent_r);
            if (is_loud) loudsec_nxt = sat_inc(loudsec_r);
            sif_nxt   = '0;
            quiet_nxt = '0;
            loud_nxt  = '0;
          end else begin
            sif_nxt   = sif_inc;
            quiet_nxt = quiet_inc;
            loud_nxt  = loud_inc;
          end
        end
      end
      ST_DIV: begin
        if (ge_s) rem_s_nxt = rem_s_r - dsh_r;
        if (ge_l) rem_l_nxt = rem_l_r - dsh_r;
        q_s_nxt = {q_s_r[QUO_W-2:0], ge_s};
        q_l_nxt = {q_l_r[QUO_W-2:0], ge_l};
        dsh_nxt = dsh_r >> 1;
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_OUT: begin
        // hold until the result register is free, then report and clear
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({pct_l, pct_s, loudsec_r, silent_r, wave});
          sif_nxt       = '0;
          quiet_nxt     = '0;
          loud_nxt      = '0;
          full_nxt      = '0;
          silent_nxt    = '0;
          loudsec_nxt   = '0;
          state_nxt     = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      sif_r       <= '0;
      quiet_r     <= '0;
      loud_r      <= '0;
      full_r      <= '0;
      silent_r    <= '0;
      loudsec_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sif_r       <= sif_nxt;
      quiet_r     <= quiet_nxt;
      loud_r      <= loud_nxt;
      full_r      <= full_nxt;
      silent_r    <= silent_nxt;
      loudsec_r   <= loudsec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_s_r    <= rem_s_nxt;
    rem_l_r    <= rem_l_nxt;
    dsh_r      <= dsh_nxt;
    q_s_r      <= q_s_nxt;
    q_l_r      <= q_l_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
